>>> design/sparse_dfa_byte_matcher_assert.svh
// assertion macros used by the matcher top level
`ifndef SPARSE_DFA_BYTE_MATCHER_ASSERT_SVH
`define SPARSE_DFA_BYTE_MATCHER_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define SDFA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define SDFA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/sdfa_pkg.sv
// types and constants of the sparse dfa byte matcher
`timescale 1ns / 1ps

package sdfa_pkg;

  localparam int STATE_W   = 4;
  localparam int SLOT_W    = 8;
  localparam int SYM_W     = 8;
  localparam int POS_W     = 16;
  localparam int MAX_LANES = 16;
  localparam logic [POS_W-1:0] POS_MAX = '1;

  typedef enum logic [1:0] {
    OP_WR_SLOT   = 2'd0,
    OP_WR_ACCEPT = 2'd1,
    OP_PROC_BYTE = 2'd2,
    OP_RESTART   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    CS_CLEAR,
    CS_IDLE,
    CS_SCAN,
    CS_TAIL,
    CS_DONE
  } ctrl_state_t;

  typedef struct packed {
    op_t                operation;
    logic [STATE_W-1:0] state_index;
    logic [SLOT_W-1:0]  slot_index;
    logic [SYM_W-1:0]   entry_symbol;
    logic [STATE_W-1:0] entry_next;
    logic               accept_value;
    logic [SYM_W-1:0]   data_byte;
  } in_item_t;

  typedef struct packed {
    logic               accepting;
    logic [STATE_W-1:0] new_state;
    logic               match_found;
    logic [POS_W-1:0]   match_position;
  } out_item_t;

  typedef struct packed {
    logic clear;
    logic wr_slot;
    logic wr_accept;
    logic restart;
    logic scan_start;
    logic issue;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic word_last;
    logic out_free;
  } dp_status_t;

endpackage

>>> design/sdfa_stream_if.sv
// valid/ready channel carrying one item per handshake
`timescale 1ns / 1ps

interface sdfa_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> design/sparse_dfa_byte_matcher.sv
// top level of the sparse dfa byte matcher
`timescale 1ns / 1ps
`include "sparse_dfa_byte_matcher_assert.svh"

// Programmable table-driven DFA over a byte stream. Every state owns a row of
// SLOTS_PER_STATE (symbol, next state) slots; symbol 0 marks a default slot.
// A process-byte item takes the last slot whose symbol equals the byte, else
// the first default slot, else keeps the state, then reports the accept flag
// of the new state and the position of the first accepting byte of the
// string. Slot writes, accept flag writes and restart give no result. A
// process-byte item is taken, then its row is read 16 slots per word through
// the single read port of the slot memory, WORDS words where WORDS is
// SLOTS_PER_STATE / 16 rounded up; the last word is folded in after its
// registered read, and then the result is formed. A finished result sits
// in an output register, so the next item is taken while it waits; a scan
// that ends while that register is still full waits until it drains. After
// reset the slot memory is zeroed one word per cycle over all its words;
// no item is accepted during that pass.
// NUM_STATES above 16 is not reachable through the 4-bit state fields.
module sparse_dfa_byte_matcher #(
  parameter int NUM_STATES      = 16,
  parameter int SLOTS_PER_STATE = 256
) (
  input  logic         clk,
  input  logic         rst_n,
  sdfa_stream_if.sink   in_if,
  sdfa_stream_if.source out_if
);
  import sdfa_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;
  in_item_t   in_payload;
  out_item_t  out_payload;

  assign in_payload     = in_if.payload;
  assign out_if.payload = out_payload;

  sdfa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_op    (in_payload.operation),
    .in_ready (in_if.ready),
    .status   (status),
    .cmd      (cmd)
  );

  sdfa_datapath #(
    .NUM_STATES      (NUM_STATES),
    .SLOTS_PER_STATE (SLOTS_PER_STATE)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_payload  (in_payload),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (out_if.valid),
    .out_ready   (out_if.ready),
    .out_payload (out_payload)
  );

  `SDFA_ASSERT_IMP(a_no_accept_in_clear, clk, rst_n, cmd.clear, !in_if.ready,
                   "item taken during clear")
  `SDFA_ASSERT_IMP(a_finish_slot_free, clk, rst_n, cmd.finish, status.out_free,
                   "result overwrites pending item")
  `SDFA_ASSERT_NXT(a_finish_shows_out, clk, rst_n, cmd.finish, out_if.valid,
                   "finished result not presented")
  `SDFA_ASSERT_IMP(a_pos_zero_no_match, clk, rst_n,
                   out_if.valid && !out_if.payload.match_found,
                   out_if.payload.match_position == '0, "position set without match")

endmodule

>>> design/sdfa_ctrl.sv
// controller: clearing pass, item decode and row scan sequencing
`timescale 1ns / 1ps

module sdfa_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  sdfa_pkg::op_t       in_op,
  output logic                in_ready,
  input  sdfa_pkg::dp_status_t status,
  output sdfa_pkg::ctrl_cmd_t  cmd
);
  import sdfa_pkg::*;

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      CS_CLEAR: begin
        if (status.clear_last) state_nxt = CS_IDLE;
      end
      CS_IDLE: begin
        if (in_valid && in_op == OP_PROC_BYTE) state_nxt = CS_SCAN;
      end
      CS_SCAN: begin
        if (status.word_last) state_nxt = CS_TAIL;
      end
      CS_TAIL: begin
        state_nxt = CS_DONE;
      end
      CS_DONE: begin
        if (status.out_free) state_nxt = CS_IDLE;
      end
      default: begin
        state_nxt = CS_CLEAR;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      CS_CLEAR: begin
        cmd.clear = 1'b1;
      end
      CS_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_op)
            OP_WR_SLOT:   cmd.wr_slot    = 1'b1;
            OP_WR_ACCEPT: cmd.wr_accept  = 1'b1;
            OP_PROC_BYTE: cmd.scan_start = 1'b1;
            OP_RESTART:   cmd.restart    = 1'b1;
            default:      cmd.restart    = 1'b0;
          endcase
        end
      end
      CS_SCAN: begin
        cmd.issue = 1'b1;
      end
      CS_TAIL: begin
        cmd.issue = 1'b0;
      end
      CS_DONE: begin
        cmd.finish = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

>>> design/sdfa_datapath.sv
// datapath: slot memory, accept flags, word scan, string state and result register
`timescale 1ns / 1ps

module sdfa_datapath #(
  parameter int NUM_STATES      = 16,
  parameter int SLOTS_PER_STATE = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sdfa_pkg::in_item_t    in_payload,
  input  sdfa_pkg::ctrl_cmd_t   cmd,
  output sdfa_pkg::dp_status_t  status,
  output logic                  out_valid,
  input  logic                  out_ready,
  output sdfa_pkg::out_item_t   out_payload
);
  import sdfa_pkg::*;

  localparam int SIDX_W  = $clog2(NUM_STATES);
  localparam int LANES   = (SLOTS_PER_STATE >= MAX_LANES) ? MAX_LANES
                         : (1 << $clog2(SLOTS_PER_STATE));
  localparam int LANE_W  = $clog2(LANES);
  localparam int WORDS   = (SLOTS_PER_STATE + LANES - 1) / LANES;
  localparam int WORD_W  = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int ADDR_W  = SIDX_W + WORD_W;
  localparam int DEPTH   = 1 << ADDR_W;
  localparam int ENTRY_W = SYM_W + SIDX_W;

  // write port
  logic [ADDR_W-1:0]  waddr;
  logic [ENTRY_W-1:0] wdata;
  logic [LANES-1:0]   we;
  logic               slot_ok;
  logic [SIDX_W-1:0]  wr_state;
  logic [WORD_W-1:0]  wr_word;
  logic [LANE_W-1:0]  wr_lane;

  // read side
  logic [ADDR_W-1:0]  raddr;
  logic               data_vld_r;
  logic [WORD_W-1:0]  data_word_r;
  logic [WORD_W-1:0]  rd_word_r;
  logic [ADDR_W-1:0]  clr_cnt_r;

  logic [SYM_W-1:0]   lane_sym [LANES];
  logic [SIDX_W-1:0]  lane_nxt [LANES];
  logic [LANES-1:0]   lane_ok;

  logic               w_hit_any, w_dflt_any;
  logic [SIDX_W-1:0]  w_hit_next, w_dflt_next;

  logic               hit_found_r, dflt_found_r;
  logic [SIDX_W-1:0]  hit_next_r, dflt_next_r;
  logic [SYM_W-1:0]   byte_r;

  // string state
  logic [SIDX_W-1:0]  cur_state_r, cur_state_nxt;
  logic [POS_W-1:0]   byte_pos_r, byte_pos_nxt;
  logic               found_r, found_nxt;
  logic [POS_W-1:0]   first_pos_r, first_pos_nxt;
  logic               acc_flags_r [NUM_STATES];

  logic [SIDX_W-1:0]  sel_state, new_st;
  logic               is_acc;
  logic               out_vld_r;
  out_item_t          out_data_r, res;

  assign wr_state = SIDX_W'(in_payload.state_index);
  assign wr_word  = WORD_W'(in_payload.slot_index >> LANE_W);
  assign wr_lane  = in_payload.slot_index[LANE_W-1:0];
  assign slot_ok  = (int'(in_payload.state_index) < NUM_STATES)
                 && (int'(in_payload.slot_index) < SLOTS_PER_STATE)
                 && (int'(in_payload.entry_next) < NUM_STATES);

  always_comb begin
    waddr = {wr_state, wr_word};
    wdata = {in_payload.entry_symbol, SIDX_W'(in_payload.entry_next)};
    we    = '0;
    if (cmd.clear) begin
      waddr = clr_cnt_r;
      wdata = '0;
      we    = '1;
    end else if (cmd.wr_slot && slot_ok) begin
      for (int l = 0; l < LANES; l++) begin
        we[l] = (wr_lane == LANE_W'(l));
      end
    end
  end

  assign raddr = {cur_state_r, rd_word_r};

  // one memory per lane, all lanes read at the same word address
  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic [ENTRY_W-1:0] mem_r [DEPTH];
    logic [ENTRY_W-1:0] rd_r;

    always_ff @(posedge clk) begin
      if (we[l]) mem_r[waddr] <= wdata;
      if (cmd.issue) rd_r <= mem_r[raddr];
    end

    assign lane_sym[l] = rd_r[ENTRY_W-1:SIDX_W];
    assign lane_nxt[l] = rd_r[SIDX_W-1:0];
    // slots past the end of a row never take part
    assign lane_ok[l]  = int'({data_word_r, LANE_W'(l)}) < SLOTS_PER_STATE;
  end

  // last matching slot and first default slot within the current word
  always_comb begin
    w_hit_any   = 1'b0;
    w_hit_next  = '0;
    w_dflt_any  = 1'b0;
    w_dflt_next = '0;
    for (int l = 0; l < LANES; l++) begin
      if (lane_ok[l] && lane_sym[l] == byte_r) begin
        w_hit_any  = 1'b1;
        w_hit_next = lane_nxt[l];
      end
    end
    for (int l = LANES - 1; l >= 0; l--) begin
      if (lane_ok[l] && lane_sym[l] == '0) begin
        w_dflt_any  = 1'b1;
        w_dflt_next = lane_nxt[l];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r    <= '0;
      rd_word_r    <= '0;
      data_vld_r   <= 1'b0;
      hit_found_r  <= 1'b0;
      dflt_found_r <= 1'b0;
    end else begin
      if (cmd.clear) clr_cnt_r <= clr_cnt_r + 1'b1;
      data_vld_r <= cmd.issue;
      if (cmd.scan_start) begin
        rd_word_r    <= '0;
        hit_found_r  <= 1'b0;
        dflt_found_r <= 1'b0;
      end else begin
        if (cmd.issue) rd_word_r <= rd_word_r + 1'b1;
        if (data_vld_r && w_hit_any) hit_found_r <= 1'b1;
        if (data_vld_r && w_dflt_any) dflt_found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) byte_r <= in_payload.data_byte;
    if (cmd.issue) data_word_r <= rd_word_r;
    if (data_vld_r && w_hit_any) hit_next_r <= w_hit_next;
    if (data_vld_r && w_dflt_any && !dflt_found_r) dflt_next_r <= w_dflt_next;
  end

  assign status.clear_last = (clr_cnt_r == ADDR_W'(DEPTH - 1));
  assign status.word_last  = (rd_word_r == WORD_W'(WORDS - 1));
  assign status.out_free   = !out_vld_r || out_ready;

  // result of the finished scan
  always_comb begin
    sel_state = hit_found_r  ? hit_next_r
              : dflt_found_r ? dflt_next_r
              : cur_state_r;
    new_st = (int'(sel_state) < NUM_STATES) ? sel_state : '0;
    is_acc = acc_flags_r[new_st];
    res.accepting      = is_acc;
    res.new_state      = STATE_W'(new_st);
    res.match_found    = found_r || is_acc;
    res.match_position = found_r ? first_pos_r : (is_acc ? byte_pos_r : '0);
  end

  always_comb begin
    cur_state_nxt = cur_state_r;
    byte_pos_nxt  = byte_pos_r;
    found_nxt     = found_r;
    first_pos_nxt = first_pos_r;
    if (cmd.restart) begin
      cur_state_nxt = '0;
      byte_pos_nxt  = '0;
      found_nxt     = 1'b0;
      first_pos_nxt = '0;
    end else if (cmd.finish) begin
      cur_state_nxt = new_st;
      if (is_acc && !found_r) begin
        found_nxt     = 1'b1;
        first_pos_nxt = byte_pos_r;
      end
      if (byte_pos_r != POS_MAX) byte_pos_nxt = byte_pos_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_state_r <= '0;
      byte_pos_r  <= '0;
      found_r     <= 1'b0;
      first_pos_r <= '0;
      out_vld_r   <= 1'b0;
      for (int s = 0; s < NUM_STATES; s++) acc_flags_r[s] <= 1'b0;
    end else begin
      cur_state_r <= cur_state_nxt;
      byte_pos_r  <= byte_pos_nxt;
      found_r     <= found_nxt;
      first_pos_r <= first_pos_nxt;
      if (cmd.finish) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
      if (cmd.wr_accept && int'(in_payload.state_index) < NUM_STATES) begin
        acc_flags_r[wr_state] <= in_payload.accept_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) out_data_r <= res;
  end

  assign out_valid   = out_vld_r;
  assign out_payload = out_data_r;

endmodule
